/* hdl/atf_pkg.sv */
// Shared types, constants and tables for the accelerometer tilt-angle filter.
// No dependencies; used by every module under hdl/.
package atf_pkg;

  localparam int unsigned SAMPLE_W = 15;  // milli-g sample width
  localparam int unsigned AXIS_W   = 16;  // filtered axis / stored average
  localparam int unsigned ABS_W    = 15;  // magnitude of one axis
  localparam int unsigned SQ_W     = 30;  // sum of squares
  localparam int unsigned ROOT_W   = 36;  // square root with 20 fraction bits
  localparam int unsigned FRAC_W   = 20;
  localparam int unsigned WEIGHT_W = 7;
  localparam int unsigned DEG_W    = 7;   // unsigned degrees 0..90
  localparam int unsigned ANGLE_W  = 8;
  localparam int unsigned MOTION_W = 16;

  // CORDIC datapath
  localparam int unsigned CORDIC_W     = 40;
  localparam int unsigned CORDIC_ITERS = 30;
  localparam int unsigned ANG_FRAC     = 30;

  // Register map
  localparam logic [2:0] ADDR_AVG_WEIGHT = 3'd0;

  // Divide by 100 via reciprocal: floor(2^28 / 100)
  localparam logic [21:0] RECIP_100 = 22'd2684354;
  localparam int unsigned RECIP_SH  = 28;

  localparam logic [9:0]  DEG_SCALE = 10'd573;  // 57.3 * 10
  localparam logic [7:0]  DIV10_MUL = 8'd205;   // n*205 >> 11 == n/10 for n < 1029
  localparam logic [6:0]  DEG_MAX   = 7'd90;
  localparam logic [15:0] ONE_G     = 16'd1000;

  // Commands from the sequencer to each lane
  typedef struct packed {
    logic filt_go;  // latch sample, run the average and the square
    logic root_go;  // sum of the other squares is valid: run root then angle
  } lane_cmd_t;

  // Lane status back to the sequencer
  typedef struct packed {
    logic busy;
  } lane_sts_t;

  // atan(2^-i) in radians with 30 fraction bits
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'd843314857;
      5'd1:    a = 32'd497837829;
      5'd2:    a = 32'd263043837;
      5'd3:    a = 32'd133525159;
      5'd4:    a = 32'd67021687;
      5'd5:    a = 32'd33543516;
      5'd6:    a = 32'd16775851;
      5'd7:    a = 32'd8388437;
      5'd8:    a = 32'd4194283;
      5'd9:    a = 32'd2097149;
      5'd10:   a = 32'd1048576;
      default: a = 32'd1 << (5'd30 - i);
    endcase
    return a;
  endfunction

endpackage

/* hdl/atf_sqrt.sv */
// Bit-serial integer square root, one result bit per cycle.
// Fraction mode appends 20 zero digit pairs. Depends on atf_pkg.
module atf_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       frac_i,
  input  logic [atf_pkg::SQ_W-1:0]   operand_i,
  output logic                       busy_o,
  output logic [atf_pkg::ROOT_W-1:0] root_o
);
  import atf_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 2;

  logic [5:0]        cnt_q, cnt_d;
  logic [SQ_W-1:0]   s_q, s_d;
  logic [REM_W-1:0]  r_q, r_d;
  logic [ROOT_W-1:0] q_q, q_d;
  logic [REM_W+1:0]  rs, t, diff;
  logic              ge;

  // one digit step
  always_comb begin
    rs   = {r_q, s_q[SQ_W-1 -: 2]};
    t    = {2'b00, q_q, 2'b01};
    ge   = (rs >= t);
    diff = rs - t;
    cnt_d = cnt_q;
    s_d   = s_q;
    r_d   = r_q;
    q_d   = q_q;
    if (start_i) begin
      cnt_d = frac_i ? 6'd35 : 6'd15;
      s_d   = operand_i;
      r_d   = '0;
      q_d   = '0;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      s_d   = {s_q[SQ_W-3:0], 2'b00};
      r_d   = ge ? diff[REM_W-1:0] : rs[REM_W-1:0];
      q_d   = {q_q[ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    r_q <= r_d;
    q_q <= q_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign root_o = q_q;
endmodule

/* hdl/atf_cordic.sv */
// Vectoring CORDIC: whole degrees 0..90 of atan(num/den), one rotation a cycle,
// then scaling to degrees. Depends on atf_pkg.
module atf_cordic (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [atf_pkg::ROOT_W-1:0] num_i,
  input  logic [atf_pkg::ROOT_W-1:0] den_i,
  output logic                       busy_o,
  output logic [atf_pkg::DEG_W-1:0]  deg_o
);
  import atf_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_ITER = 2'd1;
  localparam logic [1:0] C_MUL  = 2'd2;
  localparam logic [1:0] C_DIV  = 2'd3;

  logic [1:0]                 phase_q, phase_d;
  logic [4:0]                 i_q, i_d;
  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [31:0]         z_q, z_d;
  logic [40:0]                p_q, p_d;
  logic [DEG_W-1:0]           deg_q, deg_d;
  logic [31:0]                a;
  logic [30:0]                zc;
  logic [10:0]                t;
  logic [18:0]                tq;

  always_comb begin
    a  = atan_entry(i_q);
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    zc = z_q[31] ? 31'd0 : z_q[30:0];
    t  = p_q[40:ANG_FRAC];
    tq = 19'(t * DIV10_MUL);
    phase_d = phase_q;
    i_d = i_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    p_d = p_q;
    deg_d = deg_q;
    case (phase_q)
      C_IDLE: begin
        if (start_i) begin
          if (den_i == '0) begin
            deg_d = (num_i != '0) ? DEG_MAX : '0;
          end else begin
            x_d = CORDIC_W'($signed({1'b0, den_i}));
            y_d = CORDIC_W'($signed({1'b0, num_i}));
            z_d = '0;
            i_d = '0;
            phase_d = C_ITER;
          end
        end
      end
      C_ITER: begin
        if (!y_q[CORDIC_W-1]) begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + $signed(a);
        end else begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - $signed(a);
        end
        i_d = i_q + 5'd1;
        if (i_q == 5'(CORDIC_ITERS - 1)) begin
          phase_d = C_MUL;
        end
      end
      C_MUL: begin
        p_d = 41'(zc * DEG_SCALE);
        phase_d = C_DIV;
      end
      C_DIV: begin
        // divide by ten, then clamp to a right angle
        deg_d = (tq[18:11] > {1'b0, DEG_MAX}) ? DEG_MAX : tq[17:11];
        phase_d = C_IDLE;
      end
      default: phase_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= C_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    p_q   <= p_d;
    deg_q <= deg_d;
  end

  assign busy_o = (phase_q != C_IDLE);
  assign deg_o  = deg_q;
endmodule

/* hdl/atf_lane.sv */
// One axis lane: moving average, square, root of the other squares, CORDIC.
// Depends on atf_pkg, atf_sqrt and atf_cordic.
module atf_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  atf_pkg::lane_cmd_t           cmd_i,
  input  logic                         zmode_i,   // angle to gravity: num/den swap
  input  logic [atf_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [atf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [atf_pkg::SQ_W-1:0]     sq_other_i,
  output atf_pkg::lane_sts_t           sts_o,
  output logic [atf_pkg::SQ_W-1:0]     sq_o,
  output logic [atf_pkg::ANGLE_W-1:0]  angle_o
);
  import atf_pkg::*;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_V    = 3'd1;
  localparam logic [2:0] L_P    = 3'd2;
  localparam logic [2:0] L_Q    = 3'd3;
  localparam logic [2:0] L_SQ   = 3'd4;
  localparam logic [2:0] L_WAIT = 3'd5;
  localparam logic [2:0] L_ROOT = 3'd6;
  localparam logic [2:0] L_ANG  = 3'd7;

  logic [2:0]               phase_q, phase_d;
  logic signed [AXIS_W-1:0] avg_q, avg_d;
  logic signed [AXIS_W-1:0] axis_q, axis_d;
  logic signed [SAMPLE_W-1:0] smp_q;
  logic signed [22:0]       v_q;
  logic [42:0]              prod_q;
  logic [SQ_W-1:0]          sq_q;
  logic [ANGLE_W-1:0]       angle_q;
  logic                     en;
  logic [20:0]              vmag;
  logic [14:0]              qm, qc;
  logic [21:0]              rem, remc;
  logic signed [AXIS_W-1:0] qs;
  logic [ABS_W-1:0]         amag;
  logic [ROOT_W-1:0]        root, own, num, den;
  logic                     sq_busy, co_busy, co_start;
  logic [DEG_W-1:0]         deg;

  assign en = (weight_i != '0) && (weight_i < 7'd100);

  // divide by 100 with rounding on the positive side
  always_comb begin
    vmag = v_q[22] ? 21'(-v_q) : v_q[20:0];
    qm   = prod_q[RECIP_SH +: 15];
    rem  = {1'b0, vmag} - 22'(qm * 7'd100);
    qc   = (rem >= 22'd100) ? qm + 15'd1 : qm;
    remc = (rem >= 22'd100) ? rem - 22'd100 : rem;
    if (v_q[22]) begin
      qs = -$signed({1'b0, qc});
    end else begin
      qs = $signed({1'b0, qc}) + ((remc > 22'd49) ? 16'sd1 : 16'sd0);
    end
  end

  assign amag = axis_q[AXIS_W-1] ? ABS_W'(-axis_q) : axis_q[ABS_W-1:0];
  assign own  = ROOT_W'({amag, FRAC_W'(0)});
  assign num  = zmode_i ? root : own;
  assign den  = zmode_i ? own : root;
  assign co_start = (phase_q == L_ROOT) && !sq_busy;

  // lane sequencer
  always_comb begin
    phase_d = phase_q;
    avg_d   = avg_q;
    axis_d  = axis_q;
    case (phase_q)
      L_IDLE: if (cmd_i.filt_go) phase_d = L_V;
      L_V:    phase_d = L_P;
      L_P:    phase_d = L_Q;
      L_Q: begin
        if (en) begin
          axis_d = qs;
          avg_d  = qs;
        end else begin
          axis_d = AXIS_W'(smp_q);
        end
        phase_d = L_SQ;
      end
      L_SQ:   phase_d = L_WAIT;
      L_WAIT: if (cmd_i.root_go) phase_d = L_ROOT;
      L_ROOT: if (!sq_busy) phase_d = L_ANG;
      L_ANG:  if (!co_busy) phase_d = L_IDLE;
      default: phase_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= L_IDLE;
      avg_q   <= '0;
    end else begin
      phase_q <= phase_d;
      avg_q   <= avg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.filt_go) smp_q <= sample_i;
    v_q    <= 23'(smp_q * $signed({1'b0, weight_i}))
            + 23'(avg_q * $signed({1'b0, 7'd100 - weight_i}));
    prod_q <= 43'(vmag * RECIP_100);
    axis_q <= axis_d;
    if (phase_q == L_SQ) sq_q <= SQ_W'(amag * amag);
    if ((phase_q == L_ANG) && !co_busy) begin
      angle_q <= axis_q[AXIS_W-1] ? -ANGLE_W'(deg) : ANGLE_W'(deg);
    end
  end

  atf_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.root_go),
    .frac_i    (1'b1),
    .operand_i (sq_other_i),
    .busy_o    (sq_busy),
    .root_o    (root)
  );

  atf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (co_start),
    .num_i   (num),
    .den_i   (den),
    .busy_o  (co_busy),
    .deg_o   (deg)
  );

  assign sts_o.busy = (phase_q != L_IDLE) && (phase_q != L_WAIT);
  assign sq_o    = sq_q;
  assign angle_o = angle_q;
endmodule

/* hdl/accel_tilt_angle_filter.sv */
// Accelerometer tilt-angle filter: three axis lanes in parallel plus a motion root.
// Steps from input transfer to output valid: filter and square, start of the roots, root steps,
// CORDIC start, rotations, scaling to degrees, then storing the angles and loading the output;
// an all-zero sample skips the rotations and the scaling. One item at a time: the next item is
// taken once the result is loaded into the output register, which waits while that register
// still holds an unaccepted result. Reset (async, active low) clears weight, averages, control.
module accel_tilt_angle_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // accel_x[14:0], accel_y[29:15], accel_z[44:30]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // angle_x[7:0], angle_y[15:8], angle_z[23:16],
                                        // motion_level[39:24]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import atf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILT = 2'd1;
  localparam logic [1:0] S_ROOT = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [WEIGHT_W-1:0] weight_q;
  logic                ovalid_q;
  logic [39:0]         odata_q;
  logic                in_xfer, any_busy, mo_busy, load_out;
  lane_cmd_t           cmd;
  lane_sts_t           sts [3];
  logic [SQ_W-1:0]     sq [3];
  logic [SQ_W-1:0]     sq_other [3];
  logic [ANGLE_W-1:0]  ang [3];
  logic [SAMPLE_W-1:0] smp [3];
  logic [ROOT_W-1:0]   mroot;
  logic [SQ_W-1:0]     sq_all;
  logic [MOTION_W-1:0] motion;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {25'd0, weight_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= '0;
    end else if (psel && penable && pwrite && (paddr == ADDR_AVG_WEIGHT)) begin
      weight_q <= pwdata[WEIGHT_W-1:0];
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign any_busy = sts[0].busy || sts[1].busy || sts[2].busy || mo_busy;
  assign load_out = (state_q == S_OUT) && (!ovalid_q || m_axis_tready_i);

  assign cmd.filt_go = in_xfer;
  assign cmd.root_go = (state_q == S_FILT) && !any_busy;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_xfer) state_d = S_FILT;
      S_FILT: if (!any_busy) state_d = S_ROOT;
      S_ROOT: if (!any_busy) state_d = S_OUT;
      S_OUT:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // merge: other-axis sums for each lane and the full sum for motion
  assign smp[0] = s_axis_tdata_i[14:0];
  assign smp[1] = s_axis_tdata_i[29:15];
  assign smp[2] = s_axis_tdata_i[44:30];
  assign sq_other[0] = sq[1] + sq[2];
  assign sq_other[1] = sq[0] + sq[2];
  assign sq_other[2] = sq[0] + sq[1];
  assign sq_all      = sq_other[2] + sq[2];
  assign motion = MOTION_W'(mroot) - ONE_G;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    atf_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .zmode_i    (g == 2),
      .weight_i   (weight_q),
      .sample_i   (smp[g]),
      .sq_other_i (sq_other[g]),
      .sts_o      (sts[g]),
      .sq_o       (sq[g]),
      .angle_o    (ang[g])
    );
  end

  atf_sqrt u_motion_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd.root_go),
    .frac_i    (1'b0),
    .operand_i (sq_all),
    .busy_o    (mo_busy),
    .root_o    (mroot)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (load_out) odata_q <= {motion, ang[2], ang[1], ang[0]};
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

  // lanes are free whenever a new input may be taken
  a_idle_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !any_busy)
    else $error("lane busy while accepting input");

  // a transfer starts the lanes
  a_lane_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (sts[0].busy && sts[1].busy && sts[2].busy))
    else $error("lanes did not start after input transfer");

  // a result is loaded only when the output register can take it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!ovalid_q || m_axis_tready_i))
    else $error("result register overwritten");

endmodule
